[rtl/raycs_pkg.sv]
// ============================================================================
// raycs_pkg
// Shared types and constants for the raycast column setup unit.
// ============================================================================
package raycs_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int DELTA_W    = 32;
    localparam int QUOT_W     = 64;
    localparam int ROOT_W     = 32;
    localparam int SREM_W     = 34;

    // plane_y reset, Q16 scale (about 0.66)
    localparam logic [63:0] PLANE_Y_RST_Q16 = 64'd43253;

    typedef enum logic [2:0] {
        REG_POS_X        = 3'd0,
        REG_POS_Y        = 3'd1,
        REG_DIR_X        = 3'd2,
        REG_DIR_Y        = 3'd3,
        REG_PLANE_X      = 3'd4,
        REG_PLANE_Y      = 3'd5,
        REG_SCREEN_WIDTH = 3'd6
    } t_reg_idx;

endpackage

[rtl/raycast_column_setup_unit.sv]
// ============================================================================
// raycast_column_setup_unit
// Ray setup for one screen column of a grid raycaster: camera coordinate,
// ray direction, start cell, delta and side distances, step signs.
// ============================================================================
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+-------------------------------
//  command   | start / busy (busy always low)  | i_column
//  result    | o_result_valid (one cycle)      | o_ray_dir_*, o_cell_*, o_delta_*,
//            |                                 | o_step_*_negative, o_side_*
//  config    | APB psel/penable/pwrite, pready | paddr, pwdata, prdata
//
//  A transaction can enter every cycle. The pipeline is an input register, the
//  COLUMN_BITS + FRAC_BITS + 1 stages of the bit-per-stage camera divider and
//  103 fixed stages: product, ray, square, seed, the 64-stage delta divider,
//  the 32-stage square root, delta select, side product and output register.
//  Reset (synchronous, active low) clears the valid bits of every stage and
//  loads the camera registers with their defaults; data registers are not reset.
//  The receiver cannot stall, so the pipeline never stalls and busy stays low.
//
module raycast_column_setup_unit #(
    parameter int FRAC_BITS     = 16,
    parameter int MAP_CELL_BITS = 8,
    parameter int COLUMN_BITS   = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic [COLUMN_BITS-1:0]                 i_column,
    // result channel
    output logic                                   o_result_valid,
    output logic signed [FRAC_BITS+2:0]            o_ray_dir_x,
    output logic signed [FRAC_BITS+2:0]            o_ray_dir_y,
    output logic [MAP_CELL_BITS-1:0]               o_cell_x,
    output logic [MAP_CELL_BITS-1:0]               o_cell_y,
    output logic [raycs_pkg::DELTA_W-1:0]          o_delta_x,
    output logic [raycs_pkg::DELTA_W-1:0]          o_delta_y,
    output logic                                   o_step_x_negative,
    output logic                                   o_step_y_negative,
    output logic [raycs_pkg::DELTA_W-1:0]          o_side_x,
    output logic [raycs_pkg::DELTA_W-1:0]          o_side_y,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [raycs_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [raycs_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [raycs_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                   pready
);
    import raycs_pkg::*;

    localparam int F        = FRAC_BITS;
    localparam int POS_W    = MAP_CELL_BITS + F;
    localparam int DIR_W    = F + 2;
    localparam int RAY_W    = F + 3;
    localparam int WID_W    = COLUMN_BITS + 1;
    localparam int CQ_W     = COLUMN_BITS + F + 1;   // camera quotient
    localparam int CAM_W    = CQ_W + 1;
    localparam int PROD_W   = DIR_W + CAM_W;
    localparam int TSUM_W   = PROD_W - F + 1;
    localparam int SQR_W    = 2 * F + 5;             // square of a ray magnitude
    localparam int SUM_W    = 2 * F + 6;
    localparam int REM_W    = SQR_W;
    localparam int NUM_W    = (SUM_W + 2 * F > QUOT_W + 1) ? SUM_W + 2 * F : QUOT_W + 1;
    localparam int SAT_SH   = QUOT_W - 2 * F;
    localparam int CMP_W    = SQR_W + SAT_SH;
    localparam int SPROD_W  = F + 1 + DELTA_W;
    localparam int NDIV     = QUOT_W;
    localparam int NSQ      = ROOT_W;
    localparam int CHAIN    = NDIV + NSQ;

    localparam logic [DIR_W-1:0] DIR_X_RST   = DIR_W'(64'd1 << F);
    localparam logic [DIR_W-1:0] PLANE_Y_RST = DIR_W'((PLANE_Y_RST_Q16 << F) >> 16);
    localparam logic [WID_W-1:0] WIDTH_RST   = WID_W'(640);
    localparam logic signed [CAM_W-1:0]  CAM_ONE = CAM_W'(64'd1 << F);
    localparam logic signed [TSUM_W-1:0] RAY_HI  = TSUM_W'((64'd1 << (RAY_W - 1)) - 64'd1);
    localparam logic signed [TSUM_W-1:0] RAY_LO  = -RAY_HI - TSUM_W'(1);
    localparam logic [DELTA_W-1:0]       DELTA_ONE = DELTA_W'(64'd1 << F);
    localparam logic [F:0]               FRAC_ONE  = (F+1)'(64'd1 << F);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [POS_W-1:0] r_pos_x, r_pos_y;
    logic [DIR_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [WID_W-1:0] r_screen_width;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x        <= '0;
            r_pos_y        <= '0;
            r_dir_x        <= DIR_X_RST;
            r_dir_y        <= '0;
            r_plane_x      <= '0;
            r_plane_y      <= PLANE_Y_RST;
            r_screen_width <= WIDTH_RST;
        end else if (cfg_wr) begin
            // an address past the last register is dropped
            unique case (cfg_idx)
                REG_POS_X:        r_pos_x        <= pwdata[POS_W-1:0];
                REG_POS_Y:        r_pos_y        <= pwdata[POS_W-1:0];
                REG_DIR_X:        r_dir_x        <= pwdata[DIR_W-1:0];
                REG_DIR_Y:        r_dir_y        <= pwdata[DIR_W-1:0];
                REG_PLANE_X:      r_plane_x      <= pwdata[DIR_W-1:0];
                REG_PLANE_Y:      r_plane_y      <= pwdata[DIR_W-1:0];
                REG_SCREEN_WIDTH: r_screen_width <= pwdata[WID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_POS_X:        prdata = APB_DATA_W'(r_pos_x);
            REG_POS_Y:        prdata = APB_DATA_W'(r_pos_y);
            REG_DIR_X:        prdata = APB_DATA_W'(r_dir_x);
            REG_DIR_Y:        prdata = APB_DATA_W'(r_dir_y);
            REG_PLANE_X:      prdata = APB_DATA_W'(r_plane_x);
            REG_PLANE_Y:      prdata = APB_DATA_W'(r_plane_y);
            REG_SCREEN_WIDTH: prdata = APB_DATA_W'(r_screen_width);
            default:          prdata = '0;
        endcase
    end

    // Configuration is to change only while the pipeline is empty: the user must ensure
    // this, as the block does not enforce it. Every stage reads the live registers.
    logic [WID_W-1:0] width_eff;
    assign width_eff = (r_screen_width == '0) ? WID_W'(1) : r_screen_width;

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Camera divider: (column << (F+1)) / width, one quotient bit a stage
    // ------------------------------------------------------------------
    logic                   r_c_v   [0:CQ_W];
    logic [COLUMN_BITS-1:0] r_c_col [0:CQ_W];
    logic [WID_W-1:0]       r_c_rem [0:CQ_W];
    logic [CQ_W-1:0]        r_c_q   [0:CQ_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v[0] <= 1'b0;
        end else begin
            r_c_v[0] <= start & ~busy;
        end
        r_c_col[0] <= i_column;
        r_c_rem[0] <= '0;
        r_c_q[0]   <= '0;
    end

    for (genvar k = 0; k < CQ_W; k++) begin : g_cdiv
        localparam int J = CQ_W - 1 - k;
        logic           nbit;
        logic [WID_W:0] t;
        logic           ge;
        if (J >= F + 1) begin : g_bit
            assign nbit = r_c_col[k][J-F-1];
        end else begin : g_zero
            assign nbit = 1'b0;
        end
        assign t  = {r_c_rem[k], nbit};
        assign ge = (t >= {1'b0, width_eff});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_v[k+1] <= 1'b0;
            end else begin
                r_c_v[k+1] <= r_c_v[k];
            end
            r_c_col[k+1] <= r_c_col[k];
            r_c_rem[k+1] <= ge ? WID_W'(t - {1'b0, width_eff}) : WID_W'(t);
            r_c_q[k+1]   <= {r_c_q[k][CQ_W-2:0], ge};
        end
    end

    // ------------------------------------------------------------------
    // Plane times camera coordinate
    // ------------------------------------------------------------------
    logic signed [CAM_W-1:0]  cam;
    logic signed [PROD_W-1:0] n_b_px, n_b_py;
    logic                     r_b_v;
    logic signed [PROD_W-1:0] r_b_px, r_b_py;

    assign cam    = $signed({1'b0, r_c_q[CQ_W]}) - CAM_ONE;
    assign n_b_px = $signed(r_plane_x) * cam;
    assign n_b_py = $signed(r_plane_y) * cam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_c_v[CQ_W];
        end
        r_b_px <= n_b_px;
        r_b_py <= n_b_py;
    end

    // ------------------------------------------------------------------
    // Ray = dir + floor(product / ONE), saturated to the ray range
    // ------------------------------------------------------------------
    logic signed [TSUM_W-1:0] sum_x, sum_y;
    logic signed [RAY_W-1:0]  n_c_rx, n_c_ry;
    logic                     r_c2_v;
    logic signed [RAY_W-1:0]  r_c2_rx, r_c2_ry;

    assign sum_x = $signed(r_dir_x) + $signed(r_b_px[PROD_W-1:F]);
    assign sum_y = $signed(r_dir_y) + $signed(r_b_py[PROD_W-1:F]);

    always_comb begin
        priority if (sum_x > RAY_HI) n_c_rx = RAY_HI[RAY_W-1:0];
        else if (sum_x < RAY_LO)     n_c_rx = RAY_LO[RAY_W-1:0];
        else                         n_c_rx = sum_x[RAY_W-1:0];
        priority if (sum_y > RAY_HI) n_c_ry = RAY_HI[RAY_W-1:0];
        else if (sum_y < RAY_LO)     n_c_ry = RAY_LO[RAY_W-1:0];
        else                         n_c_ry = sum_y[RAY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_v <= 1'b0;
        end else begin
            r_c2_v <= r_b_v;
        end
        r_c2_rx <= n_c_rx;
        r_c2_ry <= n_c_ry;
    end

    // ------------------------------------------------------------------
    // Squares of the ray components
    // ------------------------------------------------------------------
    logic [RAY_W-1:0]   mag_x, mag_y;
    logic [2*RAY_W-1:0] sqfull_x, sqfull_y;
    logic               r_q_v;
    logic [SQR_W-1:0]   r_q_sqx, r_q_sqy;
    logic [RAY_W-1:0]   r_q_rx, r_q_ry;

    assign mag_x    = r_c2_rx[RAY_W-1] ? RAY_W'(-r_c2_rx) : RAY_W'(r_c2_rx);
    assign mag_y    = r_c2_ry[RAY_W-1] ? RAY_W'(-r_c2_ry) : RAY_W'(r_c2_ry);
    assign sqfull_x = mag_x * mag_x;
    assign sqfull_y = mag_y * mag_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else begin
            r_q_v <= r_c2_v;
        end
        r_q_sqx <= sqfull_x[SQR_W-1:0];
        r_q_sqy <= sqfull_y[SQR_W-1:0];
        r_q_rx  <= r_c2_rx;
        r_q_ry  <= r_c2_ry;
    end

    // ------------------------------------------------------------------
    // Sum of squares, saturation test, divider seed
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] ssum;
    logic [NUM_W-1:0] num;
    logic             sat_x, sat_y;

    assign ssum  = SUM_W'(r_q_sqx) + SUM_W'(r_q_sqy);
    assign num   = NUM_W'(ssum) << (2 * F);
    // integer part of s/d at or beyond 2^(64-2F) does not fit the quotient
    assign sat_x = (CMP_W'(ssum) >= {r_q_sqx, SAT_SH'(0)});
    assign sat_y = (CMP_W'(ssum) >= {r_q_sqy, SAT_SH'(0)});

    // carried fields, one entry per stage of divider and root
    logic             r_k_v    [0:CHAIN];
    logic [RAY_W-1:0] r_k_rx   [0:CHAIN];
    logic [RAY_W-1:0] r_k_ry   [0:CHAIN];
    logic             r_k_satx [0:CHAIN];
    logic             r_k_saty [0:CHAIN];

    logic [SUM_W-1:0]  r_d_s    [0:NDIV];
    logic [SQR_W-1:0]  r_d_sqx  [0:NDIV];
    logic [SQR_W-1:0]  r_d_sqy  [0:NDIV];
    logic [REM_W-1:0]  r_d_remx [0:NDIV];
    logic [REM_W-1:0]  r_d_remy [0:NDIV];
    logic [QUOT_W-1:0] r_d_qx   [0:NDIV];
    logic [QUOT_W-1:0] r_d_qy   [0:NDIV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_v[0] <= 1'b0;
        end else begin
            r_k_v[0] <= r_q_v;
        end
        r_k_rx[0]   <= r_q_rx;
        r_k_ry[0]   <= r_q_ry;
        r_k_satx[0] <= sat_x;
        r_k_saty[0] <= sat_y;
        r_d_s[0]    <= ssum;
        r_d_sqx[0]  <= r_q_sqx;
        r_d_sqy[0]  <= r_q_sqy;
        r_d_remx[0] <= REM_W'(num >> QUOT_W);
        r_d_remy[0] <= REM_W'(num >> QUOT_W);
        r_d_qx[0]   <= '0;
        r_d_qy[0]   <= '0;
    end

    // ------------------------------------------------------------------
    // Delta dividers: (s << 2F) / ray^2, one quotient bit a stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NDIV; k++) begin : g_ddiv
        localparam int B = QUOT_W - 1 - k;
        logic           nbit;
        logic [REM_W:0] tx, ty;
        logic           gex, gey;
        if (B >= 2 * F && B - 2 * F < SUM_W) begin : g_bit
            assign nbit = r_d_s[k][B-2*F];
        end else begin : g_zero
            assign nbit = 1'b0;
        end
        assign tx  = {r_d_remx[k], nbit};
        assign ty  = {r_d_remy[k], nbit};
        assign gex = (tx >= {1'b0, r_d_sqx[k]});
        assign gey = (ty >= {1'b0, r_d_sqy[k]});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_k_v[k+1] <= 1'b0;
            end else begin
                r_k_v[k+1] <= r_k_v[k];
            end
            r_k_rx[k+1]   <= r_k_rx[k];
            r_k_ry[k+1]   <= r_k_ry[k];
            r_k_satx[k+1] <= r_k_satx[k];
            r_k_saty[k+1] <= r_k_saty[k];
            r_d_s[k+1]    <= r_d_s[k];
            r_d_sqx[k+1]  <= r_d_sqx[k];
            r_d_sqy[k+1]  <= r_d_sqy[k];
            r_d_remx[k+1] <= gex ? REM_W'(tx - {1'b0, r_d_sqx[k]}) : REM_W'(tx);
            r_d_remy[k+1] <= gey ? REM_W'(ty - {1'b0, r_d_sqy[k]}) : REM_W'(ty);
            r_d_qx[k+1]   <= {r_d_qx[k][QUOT_W-2:0], gex};
            r_d_qy[k+1]   <= {r_d_qy[k][QUOT_W-2:0], gey};
        end
    end

    // ------------------------------------------------------------------
    // Square roots, one root bit a stage
    // ------------------------------------------------------------------
    logic [QUOT_W-1:0] r_s_qx    [1:NSQ];
    logic [QUOT_W-1:0] r_s_qy    [1:NSQ];
    logic [SREM_W-1:0] r_s_remx  [1:NSQ];
    logic [SREM_W-1:0] r_s_remy  [1:NSQ];
    logic [ROOT_W-1:0] r_s_rootx [1:NSQ];
    logic [ROOT_W-1:0] r_s_rooty [1:NSQ];

    for (genvar m = 0; m < NSQ; m++) begin : g_sqrt
        logic [QUOT_W-1:0]   qx, qy;
        logic [SREM_W-1:0]   remx, remy;
        logic [ROOT_W-1:0]   rootx, rooty;
        logic [SREM_W+1:0]   shx, shy, trx, try_;
        logic                gex, gey;
        if (m == 0) begin : g_first
            assign qx    = r_d_qx[NDIV];
            assign qy    = r_d_qy[NDIV];
            assign remx  = '0;
            assign remy  = '0;
            assign rootx = '0;
            assign rooty = '0;
        end else begin : g_next
            assign qx    = r_s_qx[m];
            assign qy    = r_s_qy[m];
            assign remx  = r_s_remx[m];
            assign remy  = r_s_remy[m];
            assign rootx = r_s_rootx[m];
            assign rooty = r_s_rooty[m];
        end
        assign shx  = {remx, qx[QUOT_W-1-2*m -: 2]};
        assign shy  = {remy, qy[QUOT_W-1-2*m -: 2]};
        assign trx  = (SREM_W+2)'({rootx, 2'b01});
        assign try_ = (SREM_W+2)'({rooty, 2'b01});
        assign gex  = (shx >= trx);
        assign gey  = (shy >= try_);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_k_v[NDIV+m+1] <= 1'b0;
            end else begin
                r_k_v[NDIV+m+1] <= r_k_v[NDIV+m];
            end
            r_k_rx[NDIV+m+1]   <= r_k_rx[NDIV+m];
            r_k_ry[NDIV+m+1]   <= r_k_ry[NDIV+m];
            r_k_satx[NDIV+m+1] <= r_k_satx[NDIV+m];
            r_k_saty[NDIV+m+1] <= r_k_saty[NDIV+m];
            r_s_qx[m+1]    <= qx;
            r_s_qy[m+1]    <= qy;
            r_s_remx[m+1]  <= gex ? SREM_W'(shx - trx) : SREM_W'(shx);
            r_s_remy[m+1]  <= gey ? SREM_W'(shy - try_) : SREM_W'(shy);
            r_s_rootx[m+1] <= {rootx[ROOT_W-2:0], gex};
            r_s_rooty[m+1] <= {rooty[ROOT_W-2:0], gey};
        end
    end

    // ------------------------------------------------------------------
    // Delta select: zero and axis-aligned rays, saturation
    // ------------------------------------------------------------------
    logic               rx_zero, ry_zero;
    logic [DELTA_W-1:0] n_f_dx, n_f_dy;
    logic               r_f_v;
    logic [DELTA_W-1:0] r_f_dx, r_f_dy;
    logic [RAY_W-1:0]   r_f_rx, r_f_ry;

    assign rx_zero = (r_k_rx[CHAIN] == '0);
    assign ry_zero = (r_k_ry[CHAIN] == '0);

    always_comb begin
        priority if (ry_zero)    n_f_dx = '0;
        else if (rx_zero)        n_f_dx = DELTA_ONE;
        else if (r_k_satx[CHAIN]) n_f_dx = '1;
        else                     n_f_dx = DELTA_W'(r_s_rootx[NSQ]);
        priority if (rx_zero)    n_f_dy = '0;
        else if (ry_zero)        n_f_dy = DELTA_ONE;
        else if (r_k_saty[CHAIN]) n_f_dy = '1;
        else                     n_f_dy = DELTA_W'(r_s_rooty[NSQ]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= r_k_v[CHAIN];
        end
        r_f_dx <= n_f_dx;
        r_f_dy <= n_f_dy;
        r_f_rx <= r_k_rx[CHAIN];
        r_f_ry <= r_k_ry[CHAIN];
    end

    // ------------------------------------------------------------------
    // Side distance products
    // ------------------------------------------------------------------
    logic [F:0]         frac_x, frac_y, fx, fy;
    logic               r_g_v;
    logic [SPROD_W-1:0] r_g_px, r_g_py;
    logic [DELTA_W-1:0] r_g_dx, r_g_dy;
    logic [RAY_W-1:0]   r_g_rx, r_g_ry;

    assign frac_x = {1'b0, r_pos_x[F-1:0]};
    assign frac_y = {1'b0, r_pos_y[F-1:0]};
    // a negative step walks back to the cell's lower edge
    assign fx = r_f_rx[RAY_W-1] ? frac_x : FRAC_ONE - frac_x;
    assign fy = r_f_ry[RAY_W-1] ? frac_y : FRAC_ONE - frac_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else begin
            r_g_v <= r_f_v;
        end
        r_g_px <= SPROD_W'(fx) * SPROD_W'(r_f_dx);
        r_g_py <= SPROD_W'(fy) * SPROD_W'(r_f_dy);
        r_g_dx <= r_f_dx;
        r_g_dy <= r_f_dy;
        r_g_rx <= r_f_rx;
        r_g_ry <= r_f_ry;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [SPROD_W-F-1:0] shx, shy;
    logic                 r_o_v;
    logic [RAY_W-1:0]     r_o_rx, r_o_ry;
    logic [DELTA_W-1:0]   r_o_dx, r_o_dy, r_o_sx, r_o_sy;
    logic [MAP_CELL_BITS-1:0] r_o_cx, r_o_cy;

    assign shx = r_g_px[SPROD_W-1:F];
    assign shy = r_g_py[SPROD_W-1:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_g_v;
        end
        r_o_rx <= r_g_rx;
        r_o_ry <= r_g_ry;
        r_o_dx <= r_g_dx;
        r_o_dy <= r_g_dy;
        r_o_sx <= (shx[SPROD_W-F-1:DELTA_W] != '0) ? '1 : shx[DELTA_W-1:0];
        r_o_sy <= (shy[SPROD_W-F-1:DELTA_W] != '0) ? '1 : shy[DELTA_W-1:0];
        r_o_cx <= r_pos_x[POS_W-1:F];
        r_o_cy <= r_pos_y[POS_W-1:F];
    end

    assign o_result_valid    = r_o_v;
    assign o_ray_dir_x       = r_o_rx;
    assign o_ray_dir_y       = r_o_ry;
    assign o_cell_x          = r_o_cx;
    assign o_cell_y          = r_o_cy;
    assign o_delta_x         = r_o_dx;
    assign o_delta_y         = r_o_dy;
    assign o_step_x_negative = r_o_rx[RAY_W-1];
    assign o_step_y_negative = r_o_ry[RAY_W-1];
    assign o_side_x          = r_o_sx;
    assign o_side_y          = r_o_sy;

endmodule

[rtl/raycs_checker.sv]
// ============================================================================
// raycs_checker
// Port-level checks for the raycast column setup unit.
// ============================================================================
module raycs_checker #(
    parameter int FRAC_BITS     = 16,
    parameter int MAP_CELL_BITS = 8,
    parameter int COLUMN_BITS   = 12
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   o_result_valid,
    input logic signed [FRAC_BITS+2:0]            o_ray_dir_x,
    input logic signed [FRAC_BITS+2:0]            o_ray_dir_y,
    input logic [raycs_pkg::DELTA_W-1:0]          o_delta_x,
    input logic [raycs_pkg::DELTA_W-1:0]          o_delta_y,
    input logic                                   o_step_x_negative,
    input logic [raycs_pkg::DELTA_W-1:0]          o_side_x,
    input logic [raycs_pkg::DELTA_W-1:0]          o_side_y
);
    import raycs_pkg::*;

    localparam int LAT = COLUMN_BITS + FRAC_BITS + 105;

    // every result traces back to an earlier accepted start
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LAT))
        else $error("result without matching start");

    a_ray_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_ray_dir_y == '0) |-> (o_delta_x == '0 && o_side_x == '0))
        else $error("zero y ray must give zero x distances");

    a_step_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_step_x_negative == o_ray_dir_x[FRAC_BITS+2]))
        else $error("x step sign mismatch");

    a_side_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_delta_y == '0) |-> (o_side_y == '0))
        else $error("zero y delta must give zero y side");

endmodule

bind raycast_column_setup_unit raycs_checker #(
    .FRAC_BITS     (FRAC_BITS),
    .MAP_CELL_BITS (MAP_CELL_BITS),
    .COLUMN_BITS   (COLUMN_BITS)
) u_raycs_checker (.*);

[tb/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking bench for the raycast column setup unit: programs the camera
// over the APB port, streams column commands, predicts each ray setup
// in a scoreboard and compares every result field by field.
// ============================================================================

typedef struct {
    logic signed [18:0] rdx;
    logic signed [18:0] rdy;
    logic [7:0]         cx;
    logic [7:0]         cy;
    logic [31:0]        dx;
    logic [31:0]        dy;
    logic               nx;
    logic               ny;
    logic [31:0]        sx;
    logic [31:0]        sy;
} t_ray_setup;

class ray_scoreboard;
    t_ray_setup pending[$];
    int         errors;
    int         checked;

    logic [23:0] pos_x, pos_y;
    logic [17:0] dir_x, dir_y, plane_x, plane_y;
    logic [12:0] width;

    function void set_reset();
        pos_x = 0; pos_y = 0; dir_x = 18'd65536; dir_y = 0;
        plane_x = 0; plane_y = 18'd43253; width = 13'd640;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
        case (idx)
            raycs_pkg::REG_POS_X:        pos_x = v[23:0];
            raycs_pkg::REG_POS_Y:        pos_y = v[23:0];
            raycs_pkg::REG_DIR_X:        dir_x = v[17:0];
            raycs_pkg::REG_DIR_Y:        dir_y = v[17:0];
            raycs_pkg::REG_PLANE_X:      plane_x = v[17:0];
            raycs_pkg::REG_PLANE_Y:      plane_y = v[17:0];
            raycs_pkg::REG_SCREEN_WIDTH: width = v[12:0];
            default: ;
        endcase
    endfunction

    // dir + floor(plane*cam / ONE), clamped to the Q2.16 range
    function longint ray_comp(logic [17:0] dreg, logic [17:0] preg, longint cam);
        longint d, p, r;
        d = longint'($signed(dreg));
        p = longint'($signed(preg));
        // |p| <= 2^17 and |cam| < 2^30, so the product fits without clamping
        r = d + ((p * cam) >>> 16);
        if (r > 262143) r = 262143;
        if (r < -262144) r = -262144;
        return r;
    endfunction

    function logic [63:0] int_sqrt(logic [127:0] n);
        logic [63:0] res;
        logic [127:0] sq;
        res = 0;
        for (int b = 63; b >= 0; b--) begin
            sq = {64'd0, res | (64'd1 << b)};
            if (sq * sq <= n) res = res | (64'd1 << b);
        end
        return res;
    endfunction

    // floor(ONE*sqrt(1 + b^2/a^2)) = isqrt(floor((a^2+b^2)*2^32 / a^2))
    function logic [31:0] delta_len(longint a, longint b);
        logic [127:0] d, s, q;
        logic [63:0] root;
        d = (a < 0) ? -a : a;
        s = (b < 0) ? -b : b;
        d = d * d;
        s = d + s * s;
        if (s / d >= 128'd4294967296) return 32'hFFFF_FFFF;
        q = (s << 32) / d;
        root = int_sqrt(q);
        return (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    endfunction

    function logic [31:0] side_len(logic [23:0] pos, logic neg, logic [31:0] dl);
        logic [63:0] f, v;
        f = {48'd0, pos[15:0]};
        if (!neg) f = 64'd65536 - f;
        v = (f * dl) >> 16;
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function void note_column(logic [11:0] col);
        t_ray_setup e;
        longint w, cam, rx, ry;
        w = (width == 0) ? 1 : width;
        cam = ((longint'(col) << 17) / w) - 65536;
        rx = ray_comp(dir_x, plane_x, cam);
        ry = ray_comp(dir_y, plane_y, cam);
        e.dx = (ry == 0) ? 32'd0 : (rx == 0) ? 32'd65536 : delta_len(rx, ry);
        e.dy = (rx == 0) ? 32'd0 : (ry == 0) ? 32'd65536 : delta_len(ry, rx);
        e.rdx = rx[18:0];
        e.rdy = ry[18:0];
        e.cx = pos_x[23:16];
        e.cy = pos_y[23:16];
        e.nx = rx < 0;
        e.ny = ry < 0;
        e.sx = side_len(pos_x, e.nx, e.dx);
        e.sy = side_len(pos_y, e.ny, e.dy);
        pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
    endtask

    task check_result(t_ray_setup r);
        t_ray_setup e;
        if (pending.size() == 0) begin
            report("unexpected result", 32'd0, 32'd0);
            return;
        end
        e = pending.pop_front();
        if (r.rdx !== e.rdx) report("ray_dir_x", 32'(r.rdx), 32'(e.rdx));
        if (r.rdy !== e.rdy) report("ray_dir_y", 32'(r.rdy), 32'(e.rdy));
        if (r.cx !== e.cx) report("cell_x", 32'(r.cx), 32'(e.cx));
        if (r.cy !== e.cy) report("cell_y", 32'(r.cy), 32'(e.cy));
        if (r.dx !== e.dx) report("delta_x", r.dx, e.dx);
        if (r.dy !== e.dy) report("delta_y", r.dy, e.dy);
        if (r.nx !== e.nx) report("step_x_negative", 32'(r.nx), 32'(e.nx));
        if (r.ny !== e.ny) report("step_y_negative", 32'(r.ny), 32'(e.ny));
        if (r.sx !== e.sx) report("side_x", r.sx, e.sx);
        if (r.sy !== e.sy) report("side_y", r.sy, e.sy);
        checked++;
    endtask
endclass

module tb_top;
    import raycs_pkg::*;

    // pipeline depth of the unit with the default parameters, plus margin
    localparam int LATENCY = 12 + 16 + 106;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [11:0] i_column = 0;
    logic        o_result_valid;
    logic signed [18:0] o_ray_dir_x, o_ray_dir_y;
    logic [7:0]  o_cell_x, o_cell_y;
    logic [31:0] o_delta_x, o_delta_y, o_side_x, o_side_y;
    logic        o_step_x_negative, o_step_y_negative;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [APB_ADDR_W-1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    ray_scoreboard sb = new();
    int idle_pct;
    int columns_sent;

    always #4 i_clk = ~i_clk;

    raycast_column_setup_unit dut (.*);

    // Collect every strobed result at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            t_ray_setup r;
            r.rdx = o_ray_dir_x; r.rdy = o_ray_dir_y;
            r.cx = o_cell_x; r.cy = o_cell_y;
            r.dx = o_delta_x; r.dy = o_delta_y;
            r.nx = o_step_x_negative; r.ny = o_step_y_negative;
            r.sx = o_side_x; r.sy = o_side_y;
            sb.check_result(r);
        end
    end

    // Write one register: setup cycle, then access cycle.
    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= APB_ADDR_W'(4 * int'(idx)); pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(int'(idx), v);
    endtask

    // Hold off until the pipeline has drained.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Issue one column command; idle gaps per the current phase.
    task automatic send_column(logic [11:0] col);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_column <= col;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_column(col);
        columns_sent++;
    endtask

    task automatic end_burst();
        start <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_camera(logic [23:0] px, logic [23:0] py, logic [17:0] dx,
                              logic [17:0] dy, logic [17:0] plx, logic [17:0] ply,
                              logic [12:0] w);
        drain();
        write_reg(REG_POS_X, 32'(px));
        write_reg(REG_POS_Y, 32'(py));
        write_reg(REG_DIR_X, 32'(dx));
        write_reg(REG_DIR_Y, 32'(dy));
        write_reg(REG_PLANE_X, 32'(plx));
        write_reg(REG_PLANE_Y, 32'(ply));
        write_reg(REG_SCREEN_WIDTH, 32'(w));
    endtask

    // Random camera; mostly a unit-ish view, sometimes extreme values.
    task automatic random_camera();
        logic [12:0] w;
        w = ($urandom_range(3) == 0) ? 13'($urandom_range(4096, 0))
                                     : 13'($urandom_range(64, 1));
        set_camera(24'($urandom), 24'($urandom),
                   ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(65536)),
                   18'($urandom), 18'($urandom), 18'($urandom), w);
    endtask

    initial begin
        idle_pct = 0;
        sb.set_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset camera, edges of the screen and beyond the width.
        send_column(0); send_column(320); send_column(639);
        send_column(640); send_column(4095);
        end_burst();
        // Axis-aligned rays: zero components on each axis, both signs.
        set_camera(24'h00_8000, 24'hFF_FFFF, 18'h10000, 0, 0, 0, 2);
        send_column(1); send_column(0); send_column(2);
        end_burst();
        set_camera(24'hFF_0000, 24'h01_4000, 0, 18'h30000, 0, 0, 13'd4096);
        send_column(2048); send_column(4095);
        end_burst();
        // Extremes of the direction and plane, screen width zero.
        set_camera(24'hFF_FFFF, 0, 18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF, 0);
        send_column(0); send_column(1); send_column(4095);
        end_burst();
        // Tiny component against a large one: saturated delta and side.
        set_camera(24'h12_0001, 24'h34_FFFF, 18'h00001, 18'h1FFFF, 0, 0, 1);
        send_column(0); send_column(4095);
        end_burst();
        set_camera(24'h05_5555, 24'h0A_AAAA, 18'h3FFFF, 18'h00001, 18'h00001, 0, 3);
        send_column(0); send_column(1); send_column(2); send_column(3);
        end_burst();

        // Random phases: no idle, sender idle 63%, sender idle 38%, no idle again.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 63 : (ph == 2) ? 38 : 0;
            for (int c = 0; c < 13; c++) begin
                random_camera();
                for (int k = 0; k < 37; k++) begin
                    if (sb.width != 0 && $urandom_range(3) != 0)
                        send_column(12'($urandom_range(int'(sb.width) - 1)));
                    else
                        send_column(12'($urandom));
                end
                end_burst();
            end
        end

        drain();
        repeat (LATENCY) @(posedge i_clk);
        $display("covered %0d column commands, %0d results checked, over many camera setups",
                 columns_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end
endmodule
